>>> hdl/text_word_extractor_core_assert.svh
// assertion macros for the word extractor
// each macro expects clk and rst_n in the scope where it is used
`ifndef TEXT_WORD_EXTRACTOR_CORE_ASSERT_SVH
`define TEXT_WORD_EXTRACTOR_CORE_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define TWE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TWE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TWE_ASSERT_NOW(label, ante, cons, msg)

`define TWE_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> hdl/twe_pkg.sv
`timescale 1ns / 1ps

package twe_pkg;

  localparam int CHAR_W       = 21;
  localparam int WORD_MAX_DEF = 63;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = CHAR_W'(10);
  localparam logic [CHAR_W-1:0] CH_BS      = CHAR_W'(8);
  localparam logic [CHAR_W-1:0] CH_AMP     = CHAR_W'(38);
  localparam logic [CHAR_W-1:0] CH_QUOTE   = CHAR_W'(39);
  localparam logic [CHAR_W-1:0] CH_COMMA   = CHAR_W'(44);
  localparam logic [CHAR_W-1:0] CH_DOT     = CHAR_W'(46);
  localparam logic [CHAR_W-1:0] CH_COLON   = CHAR_W'(58);
  localparam logic [CHAR_W-1:0] CH_SEMI    = CHAR_W'(59);
  localparam logic [CHAR_W-1:0] CH_QMARK   = CHAR_W'(63);
  localparam logic [CHAR_W-1:0] CH_UNDER   = CHAR_W'(95);
  localparam logic [CHAR_W-1:0] CH_EXT_LO  = CHAR_W'(128);
  localparam logic [CHAR_W-1:0] CH_EN_DASH = CHAR_W'(32'h2013);
  localparam logic [CHAR_W-1:0] CH_EM_DASH = CHAR_W'(32'h2014);
  localparam logic [CHAR_W-1:0] CH_LC_A    = CHAR_W'(97);
  localparam logic [CHAR_W-1:0] CH_LC_Z    = CHAR_W'(122);
  localparam logic [CHAR_W-1:0] CH_UC_A    = CHAR_W'(65);
  localparam logic [CHAR_W-1:0] CH_UC_Z    = CHAR_W'(90);
  localparam logic [CHAR_W-1:0] CH_D0      = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CH_D9      = CHAR_W'(57);

  typedef enum logic [2:0] {
    CL_SPECIAL = 3'd0,
    CL_APOS    = 3'd1,
    CL_PUNCT   = 3'd2,
    CL_DIGIT   = 3'd3,
    CL_LETTER  = 3'd4,
    CL_EXT     = 3'd5
  } rune_class_t;

  // controller to datapath
  typedef struct packed {
    logic accept;     // take the rune on in_char
    logic emit_step;  // issue the next result of the word
  } twe_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic emit_req;   // presented rune closes a word worth emitting
    logic at_end;     // all kept runes issued, newline is next
    logic slot_free;  // output register can take a result this cycle
  } twe_stat_t;

  function automatic rune_class_t rune_class(input logic [CHAR_W-1:0] r);
    rune_class_t c;
    c = CL_SPECIAL;
    if (r >= CH_EXT_LO) begin
      c = (r == CH_EN_DASH || r == CH_EM_DASH) ? CL_SPECIAL : CL_EXT;
    end else if ((r >= CH_LC_A && r <= CH_LC_Z) || (r >= CH_UC_A && r <= CH_UC_Z)) begin
      c = CL_LETTER;
    end else if (r >= CH_D0 && r <= CH_D9) begin
      c = CL_DIGIT;
    end else if (r == CH_QUOTE || r == CH_AMP || r == CH_BS) begin
      c = CL_APOS;
    end else if (r == CH_DOT || r == CH_COMMA || r == CH_SEMI || r == CH_QMARK ||
                 r == CH_COLON) begin
      c = CL_PUNCT;
    end
    return c;
  endfunction

  // runes left off the end of an emitted word
  function automatic logic trimmable(input logic [CHAR_W-1:0] r, input rune_class_t c);
    return (r == CH_QUOTE) || (r == CH_AMP) || (c == CL_PUNCT);
  endfunction

endpackage

>>> hdl/twe_datapath.sv
`timescale 1ns / 1ps

`include "text_word_extractor_core_assert.svh"

module twe_datapath import twe_pkg::*; #(
  parameter int WORD_MAX = WORD_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CHAR_W-1:0] in_char,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  twe_cmd_t          cmd,
  output twe_stat_t         stat,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_word_done,
  output logic              out_truncated
);

  localparam int LEN_W = $clog2(WORD_MAX + 1);
  localparam int IDX_W = $clog2(WORD_MAX);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(WORD_MAX);

  logic              mode_r;
  logic              in_word_r, in_word_nxt;
  logic [LEN_W-1:0]  stored_len_r, stored_len_nxt;
  logic [LEN_W-1:0]  kept_len_r, kept_len_nxt;
  logic [1:0]        letters_r, letters_nxt;
  logic              ovf_r, ovf_nxt;
  logic [LEN_W-1:0]  idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_nl_r;
  logic              out_trunc_r;
  logic [CHAR_W-1:0] rd_q_r;

  logic [CHAR_W-1:0] word_mem [WORD_MAX];

  rune_class_t       cls;
  logic              us;
  logic              cont;
  logic              letter_like;
  logic              starts;
  logic              word_ok;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;

  // rune classification
  always_comb begin
    cls         = rune_class(in_char);
    us          = mode_r && (in_char == CH_UNDER);
    cont        = (cls != CL_SPECIAL) || us;
    letter_like = (cls == CL_LETTER) || us;
    starts      = (cls == CL_DIGIT) || (cls == CL_LETTER) || (cls == CL_EXT);
    word_ok     = letters_r[1];
  end

  always_comb begin
    stat.emit_req  = in_word_r && !cont && word_ok;
    stat.at_end    = (idx_r == kept_len_r);
    stat.slot_free = !out_valid_r || out_ready;
  end

  // word buffer write
  always_comb begin
    wr_en   = cmd.accept && (in_word_r ? (cont && stored_len_r < LEN_MAX) : starts);
    wr_addr = in_word_r ? stored_len_r[IDX_W-1:0] : '0;
  end

  // word state update
  always_comb begin
    in_word_nxt    = in_word_r;
    stored_len_nxt = stored_len_r;
    kept_len_nxt   = kept_len_r;
    letters_nxt    = letters_r;
    ovf_nxt        = ovf_r;
    idx_nxt        = idx_r;
    if (cmd.accept) begin
      if (in_word_r) begin
        if (cont) begin
          if (stored_len_r < LEN_MAX) begin
            stored_len_nxt = stored_len_r + 1'b1;
            if (!trimmable(in_char, cls)) begin
              kept_len_nxt = stored_len_r + 1'b1;
            end
          end else begin
            ovf_nxt = 1'b1;
          end
          if (letter_like && !letters_r[1]) begin
            letters_nxt = letters_r + 1'b1;
          end
        end else if (word_ok) begin
          // hold the word, emission starts from the first rune
          idx_nxt = '0;
        end else begin
          in_word_nxt    = 1'b0;
          stored_len_nxt = '0;
          kept_len_nxt   = '0;
          letters_nxt    = '0;
          ovf_nxt        = 1'b0;
        end
      end else if (starts) begin
        in_word_nxt    = 1'b1;
        stored_len_nxt = LEN_W'(1);
        kept_len_nxt   = LEN_W'(1);
        letters_nxt    = (cls == CL_LETTER) ? 2'd1 : 2'd0;
        ovf_nxt        = 1'b0;
      end
    end
    if (cmd.emit_step) begin
      if (stat.at_end) begin
        // newline issued, word is finished
        in_word_nxt    = 1'b0;
        stored_len_nxt = '0;
        kept_len_nxt   = '0;
        letters_nxt    = '0;
        ovf_nxt        = 1'b0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  // output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit_step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= 1'b0;
      in_word_r    <= 1'b0;
      stored_len_r <= '0;
      kept_len_r   <= '0;
      letters_r    <= '0;
      ovf_r        <= 1'b0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      in_word_r    <= in_word_nxt;
      stored_len_r <= stored_len_nxt;
      kept_len_r   <= kept_len_nxt;
      letters_r    <= letters_nxt;
      ovf_r        <= ovf_nxt;
      idx_r        <= idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // word buffer, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      word_mem[wr_addr] <= in_char;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_step && !stat.at_end) begin
      rd_q_r <= word_mem[idx_r[IDX_W-1:0]];
    end
  end

  // result payload flags
  always_ff @(posedge clk) begin
    if (cmd.emit_step) begin
      out_nl_r    <= stat.at_end;
      out_trunc_r <= ovf_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char      = out_nl_r ? CH_NEWLINE : rd_q_r;
  assign out_word_done = out_nl_r;
  assign out_truncated = out_trunc_r;

  `TWE_ASSERT_NOW(a_kept_le_stored, 1'b1, kept_len_r <= stored_len_r,
    "kept length beyond stored length")
  `TWE_ASSERT_NOW(a_idx_le_kept, cmd.emit_step, idx_r <= kept_len_r,
    "emission index past kept runes")
  `TWE_ASSERT_NEXT(a_step_loads_out, cmd.emit_step, out_valid_r,
    "issued result not held in output register")

endmodule

>>> hdl/twe_controller.sv
`timescale 1ns / 1ps

`include "text_word_extractor_core_assert.svh"

module twe_controller import twe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  twe_stat_t stat,
  output twe_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // sequencing of rune intake and word emission
  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd.accept    = 1'b0;
    cmd.emit_step = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && stat.emit_req) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.slot_free) begin
          cmd.emit_step = 1'b1;
          if (stat.at_end) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `TWE_ASSERT_NOW(a_no_overlap, 1'b1, !(cmd.accept && cmd.emit_step),
    "intake and emission in the same cycle")
  `TWE_ASSERT_NEXT(a_newline_returns, cmd.emit_step && stat.at_end, state_r == ST_IDLE,
    "controller did not return to intake after newline")

endmodule

>>> hdl/text_word_extractor_core.sv
`timescale 1ns / 1ps

// Word extractor: takes text runes on the in_ channel and returns each word of
// two or more letters on the out_ channel, one rune per item, trailing quotes,
// ampersands and punctuation trimmed, closed by a newline item with
// out_word_done high; out_truncated marks words longer than WORD_MAX runes,
// whose extra runes are dropped. cfg_wdata, written with cfg_we, sets
// underscore mode (underscore continues a word and counts as a letter). A rune
// that closes an emitted word holds off intake while its kept runes and then
// the newline are issued through the single read port of the word buffer,
// which gives one result per cycle unless out_ready stalls the output; intake
// resumes once the newline is issued. The buffer holds WORD_MAX runes and
// needs no clearing after reset.
module text_word_extractor_core import twe_pkg::*; #(
  parameter int WORD_MAX = WORD_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAR_W-1:0] in_char,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_word_done,
  output logic              out_truncated,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);

  twe_cmd_t  cmd;
  twe_stat_t stat;

  twe_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  twe_datapath #(
    .WORD_MAX (WORD_MAX)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_char       (in_char),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .cmd           (cmd),
    .stat          (stat),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_char      (out_char),
    .out_word_done (out_word_done),
    .out_truncated (out_truncated)
  );

endmodule

>>> tb/text_word_extractor_core_tb.sv
`timescale 1ns / 1ps

module text_word_extractor_core_tb;
  import twe_pkg::*;

  localparam logic [CHAR_W-1:0] CH_SPACE   = CHAR_W'(32);
  localparam logic [CHAR_W-1:0] CH_TOP     = CHAR_W'(21'h1FFFFF);
  localparam logic [CHAR_W-1:0] CH_ZERO    = CHAR_W'(0);
  localparam int                SQUEEZE_LEN  = 400;
  localparam int                DRAIN_CYCLES = 8;
  localparam int                TIMEOUT_NS   = 4_000_000;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              done;
    logic              trunc;
  } word_item_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CHAR_W-1:0] in_char = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CHAR_W-1:0] out_char;
  logic              out_word_done;
  logic              out_truncated;
  logic              cfg_we = 1'b0;
  logic              cfg_wdata = 1'b0;

  // stimulus and expected word items
  logic [CHAR_W-1:0] runes_to_send [$];
  word_item_t        word_items_due [$];
  logic              in_taken = 1'b0;
  int                send_idle_pct = 33;
  int                recv_idle_pct = 57;
  logic              squeeze_on = 1'b0;
  int                squeeze_count = 0;
  int                err_count = 0;

  // predicted extractor state
  logic              underscore_on = 1'b0;
  logic              word_open = 1'b0;
  logic [CHAR_W-1:0] word_buf [WORD_MAX_DEF];
  int                word_len = 0;
  int                keep_len = 0;
  int                letter_cnt = 0;
  logic              word_over = 1'b0;

  // apostrophe and punctuation runes for word tails; all but backspace get trimmed
  logic [CHAR_W-1:0] tail_set [8] = '{CH_QUOTE, CH_AMP, CH_BS, CH_DOT, CH_COMMA,
                                      CH_SEMI, CH_QMARK, CH_COLON};

  // opening script, underscore mode off
  logic [CHAR_W-1:0] plain_script [28] = '{
    CH_LC_A, CHAR_W'(98), CH_QUOTE, CH_DOT, CH_NEWLINE,
    CH_TOP, CH_UC_Z, CH_LC_Z, CH_ZERO,
    CH_D0, CH_D9, CH_BS, CH_AMP, CH_SPACE,
    CH_UNDER, CHAR_W'(120), CHAR_W'(121), CH_EN_DASH,
    CH_UC_A, CH_UNDER,
    CH_EXT_LO, CHAR_W'(113), CHAR_W'(114), CH_COMMA, CH_SEMI, CH_QMARK, CH_COLON,
    CH_EM_DASH
  };

  // opening script, underscore mode on
  logic [CHAR_W-1:0] under_script [9] = '{
    CH_UNDER, CH_LC_A, CH_UNDER, CH_SPACE,
    CHAR_W'(98), CH_UNDER, CH_SEMI, CH_QUOTE, CH_NEWLINE
  };

  text_word_extractor_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char      (in_char),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (out_char),
    .out_word_done(out_word_done),
    .out_truncated(out_truncated),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // rune classes as the extractor sees them
  function automatic rune_class_t classify_rune(input logic [CHAR_W-1:0] r);
    if (r == CH_EN_DASH || r == CH_EM_DASH) return CL_SPECIAL;
    if (r >= CH_EXT_LO) return CL_EXT;
    if ((r >= CH_UC_A && r <= CH_UC_Z) || (r >= CH_LC_A && r <= CH_LC_Z)) return CL_LETTER;
    if (r >= CH_D0 && r <= CH_D9) return CL_DIGIT;
    if (r == CH_BS || r == CH_AMP || r == CH_QUOTE) return CL_APOS;
    if (r == CH_COMMA || r == CH_DOT || r == CH_COLON || r == CH_SEMI || r == CH_QMARK)
      return CL_PUNCT;
    return CL_SPECIAL;
  endfunction

  task automatic expect_word_item(input logic [CHAR_W-1:0] ch, input logic done);
    word_item_t w;
    w.ch = ch;
    w.done = done;
    w.trunc = word_over;
    word_items_due.push_back(w);
  endtask

  // advance the predicted state by one accepted rune
  task automatic extract_rune(input logic [CHAR_W-1:0] r);
    rune_class_t cls;
    logic        joins;
    int          i;
    cls = classify_rune(r);
    joins = underscore_on && (r == CH_UNDER);
    if (word_open) begin
      if (cls != CL_SPECIAL || joins) begin
        if (word_len < WORD_MAX_DEF) begin
          word_buf[word_len] = r;
          word_len++;
          if (!(r == CH_QUOTE || r == CH_AMP || cls == CL_PUNCT)) keep_len = word_len;
        end else begin
          word_over = 1'b1;
        end
        if ((cls == CL_LETTER || joins) && letter_cnt < 2) letter_cnt++;
      end else begin
        if (letter_cnt >= 2) begin
          for (i = 0; i < keep_len; i++) expect_word_item(word_buf[i], 1'b0);
          expect_word_item(CH_NEWLINE, 1'b1);
        end
        word_open = 1'b0;
        word_len = 0;
        keep_len = 0;
        letter_cnt = 0;
        word_over = 1'b0;
      end
    end else if (cls == CL_LETTER || cls == CL_DIGIT || cls == CL_EXT) begin
      word_open = 1'b1;
      word_buf[0] = r;
      word_len = 1;
      keep_len = 1;
      letter_cnt = (cls == CL_LETTER) ? 1 : 0;
      word_over = 1'b0;
    end
  endtask

  function automatic logic [CHAR_W-1:0] any_letter();
    if ($urandom_range(1) != 0) return CHAR_W'($urandom_range(CH_LC_Z, CH_LC_A));
    return CHAR_W'($urandom_range(CH_UC_Z, CH_UC_A));
  endfunction

  function automatic logic [CHAR_W-1:0] any_ext();
    return CHAR_W'($urandom_range(CH_TOP, CH_EXT_LO));
  endfunction

  // one word of random content, maybe trimmable tail, then a closing rune
  task automatic queue_word(input int len);
    int                k;
    int                pick;
    logic [CHAR_W-1:0] r;
    for (k = 0; k < len; k++) begin
      pick = $urandom_range(99);
      if (k == 0) begin
        if (pick < 70) r = any_letter();
        else if (pick < 85) r = CHAR_W'($urandom_range(CH_D9, CH_D0));
        else r = any_ext();
      end else if (pick < 55) r = any_letter();
      else if (pick < 65) r = CHAR_W'($urandom_range(CH_D9, CH_D0));
      else if (pick < 73) r = any_ext();
      else if (pick < 81) r = CH_UNDER;
      else r = tail_set[$urandom_range(7)];
      runes_to_send.push_back(r);
    end
    if ($urandom_range(99) < 30) begin
      for (k = $urandom_range(3, 1); k > 0; k--)
        runes_to_send.push_back(tail_set[$urandom_range(7)]);
    end
    case ($urandom_range(4))
      0: r = CH_NEWLINE;
      1: r = CH_EN_DASH;
      2: r = CH_EM_DASH;
      3: r = CH_SPACE;
      default: begin
        r = CHAR_W'($urandom_range(127));
        while (classify_rune(r) != CL_SPECIAL || r == CH_UNDER)
          r = CHAR_W'($urandom_range(127));
      end
    endcase
    runes_to_send.push_back(r);
  endtask

  // mostly well-formed words, some raw noise, closed by a newline
  task automatic fill_random(input int target);
    int made;
    int len;
    int k;
    made = 0;
    while (made < target) begin
      if ($urandom_range(99) < 80) begin
        len = ($urandom_range(99) < 85) ? $urandom_range(8, 2) : $urandom_range(20, 9);
        queue_word(len);
        made += len + 1;
      end else begin
        len = $urandom_range(3, 1);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(1) != 0) runes_to_send.push_back(CHAR_W'($urandom));
          else runes_to_send.push_back(CHAR_W'($urandom_range(127)));
        end
        made += len;
      end
    end
    runes_to_send.push_back(CH_NEWLINE);
  endtask

  // wait until every rune is taken and every word item has come back
  task automatic settle();
    while (runes_to_send.size() != 0 || in_valid || word_items_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_underscore(input logic m);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // sender: one item held until taken, random gaps between items
  always @(negedge clk) begin : drive_side
    logic              nv;
    logic [CHAR_W-1:0] nc;
    nv = in_valid;
    nc = in_char;
    if (!rst_n) begin
      nv = 1'b0;
    end else begin
      if (in_valid && in_taken) nv = 1'b0;
      if (!nv && runes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nc = runes_to_send.pop_front();
        nv = 1'b1;
      end
    end
    in_valid <= nv;
    in_char <= nc;
  end

  // receiver: random stalls plus one long hold-off when asked
  always @(negedge clk) begin : recv_side
    logic rdy;
    rdy = ($urandom_range(99) >= recv_idle_pct);
    if (squeeze_on && squeeze_count < SQUEEZE_LEN) begin
      rdy = 1'b0;
      squeeze_count++;
    end
    out_ready <= rdy;
  end

  // predict on accepted runes, check accepted word items
  always @(posedge clk) begin : watch_side
    word_item_t w;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (cfg_we) underscore_on = cfg_wdata;
      if (in_valid && in_ready) extract_rune(in_char);
      if (out_valid && out_ready) begin
        if (word_items_due.size() == 0) begin
          $display("%0t unexpected item: expected none actual char %h done %b trunc %b",
                   $time, out_char, out_word_done, out_truncated);
          err_count++;
        end else begin
          w = word_items_due.pop_front();
          if (out_char !== w.ch) begin
            $display("%0t out_char mismatch: expected %h actual %h", $time, w.ch, out_char);
            err_count++;
          end
          if (out_word_done !== w.done) begin
            $display("%0t out_word_done mismatch: expected %b actual %b",
                     $time, w.done, out_word_done);
            err_count++;
          end
          if (out_truncated !== w.trunc) begin
            $display("%0t out_truncated mismatch: expected %b actual %b",
                     $time, w.trunc, out_truncated);
            err_count++;
          end
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("text_word_extractor_core_tb: errors");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed runes, underscore mode off
    set_underscore(1'b0);
    foreach (plain_script[i]) runes_to_send.push_back(plain_script[i]);
    settle();

    // directed runes, underscore mode on
    set_underscore(1'b1);
    foreach (under_script[i]) runes_to_send.push_back(under_script[i]);
    settle();

    // sender idles less than receiver, full and overfull words
    send_idle_pct = 33;
    recv_idle_pct = 57;
    queue_word(WORD_MAX_DEF);
    queue_word(WORD_MAX_DEF + 1);
    fill_random(10);
    settle();

    // roles swapped, underscore mode off
    set_underscore(1'b0);
    send_idle_pct = 57;
    recv_idle_pct = 33;
    fill_random(15);
    settle();

    // no idling, long receiver hold-off backs the block up
    set_underscore(1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    squeeze_on = 1'b1;
    queue_word(WORD_MAX_DEF + 3);
    fill_random(10);
    settle();

    if (err_count == 0) begin
      $display("text_word_extractor_core_tb: clean");
    end else begin
      $display("text_word_extractor_core_tb: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/twe_pkg.sv
hdl/twe_datapath.sv
hdl/twe_controller.sv
hdl/text_word_extractor_core.sv
tb/text_word_extractor_core_tb.sv
